// ===== src/ras_pkg.sv =====
// ---------------------------------------------------------------------------
// ras_pkg: shared definitions for the rotor alignment sequencer
// Beat layouts, register indexes, phase codes and fixed sequence counts.
// ---------------------------------------------------------------------------
`default_nettype none

package ras_pkg;

    // Motor pole pairs; electrical angle is the mechanical angle times this.
    localparam int unsigned POLE_PAIRS = 4;

    // Field widths.
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned VQ_W    = 15;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned PHASE_W = 3;

    // Input beat: reference_position, align_angle, index_crossed, pad to bytes.
    localparam int unsigned IN_BITS = 2 * ANGLE_W + 1;
    localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;

    // Output beat: angle, vq, sync offset, busy, done, fault, pad to bytes.
    localparam int unsigned OUT_BITS = 2 * ANGLE_W + VQ_W + 3;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_STRATEGY  = 3'd0;
    localparam logic [IDX_W-1:0] REG_VQ_LIMIT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RAMP_DIV  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SWEEP_DIR = 3'd3;
    localparam logic [IDX_W-1:0] REG_INDEX_OFS = 3'd4;

    // Sequence phases.
    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_UP_ENTER   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_UP         = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SWEEP      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DOWN_ENTER = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DOWN       = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE       = 3'd6;

    // Sweep lengths in ticks and the blind sweep offset base.
    localparam logic [COUNT_W-1:0] SWEEP_END_BLIND = COUNT_W'(32'h17000);
    localparam logic [COUNT_W-1:0] SWEEP_END_INDEX =
        COUNT_W'(32'h10000 * POLE_PAIRS + 32'h7000);
    localparam logic [ANGLE_W-1:0] SWEEP_BASE = 16'h3f00;

    // Mechanical to electrical angle, wrapping at 16 bits.
    function automatic logic [ANGLE_W-1:0] to_elec(input logic [ANGLE_W-1:0] mech);
        logic [31:0] prod;
        prod = 32'(mech) * 32'(POLE_PAIRS);
        return prod[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/ras_skid.sv =====
// ---------------------------------------------------------------------------
// ras_skid: two-entry output buffer for result beats
// Holds a result in the output register and one more in a skid register so
// the input side can take one more beat while the receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module ras_skid (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [ras_pkg::OUT_W-1:0] in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [ras_pkg::OUT_W-1:0] out_data
);
    import ras_pkg::*;

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            if (!out_valid_reg || out_ready)
                out_data_reg <= in_data;
            else
                skid_data_reg <= in_data;
        end
        else if (out_valid_reg && out_ready && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

`ifndef SYNTH
    // A beat waits in the skid register only behind a beat in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // The skid register fills only when the output register was stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled while output was free");
`endif

endmodule

`default_nettype wire

// ===== src/rotor_align_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// rotor_align_sequencer_unit: open-loop rotor alignment sequencer
// Ramps the quadrature voltage, sweeps a forced electrical angle, ramps down
// and computes the encoder sync offset, one control tick per input beat.
// ---------------------------------------------------------------------------
// Usage:
//   Each slave beat is one control tick (tuser low) or a start command
//   (tuser high). Every accepted beat yields exactly one master beat holding
//   the sequencer outputs after that beat: forced angle, voltage command,
//   sync offset and busy, done and fault flags.
//   The state update is combinational from the state registers to the
//   result, which is registered when its beat is taken, and one beat can be
//   accepted every cycle while s_axis_tready is high.
//   Results go to an output register backed by one skid register; with the
//   receiver stalled, one further beat is taken, after which s_axis_tready
//   drops until the receiver takes a beat.
//   Configuration must be written via cfg_we/cfg_index/cfg_data only while the
//   block is idle, which it does not enforce; writes to unlisted indexes are
//   ignored. Reset puts the sequencer idle with angle, voltage and offset at
//   zero and loads the register defaults (voltage limit 1000, direction +1).
// ---------------------------------------------------------------------------
`default_nettype none

module rotor_align_sequencer_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Slave side.
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: reference_position[15:0], align_angle[31:16], index_crossed[32]
    input  wire logic [ras_pkg::IN_W-1:0]    s_axis_tdata,
    // tuser: action (0 tick, 1 start)
    input  wire logic                        s_axis_tuser,
    // Master side.
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // tdata: electrical_angle[15:0], vq_drive[30:16], sync_offset[46:31],
    //        busy_res[47], done_res[48], fault[49]
    output logic      [ras_pkg::OUT_W-1:0]   m_axis_tdata,
    // Configuration write port.
    input  wire logic                        cfg_we,
    input  wire logic [ras_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [ras_pkg::CFG_W-1:0]   cfg_data
);
    import ras_pkg::*;

    // Configuration registers.
    logic               strategy_reg;
    logic [VQ_W-1:0]    vq_limit_reg;
    logic [DIV_W-1:0]   ramp_div_reg;
    logic [ANGLE_W-1:0] sweep_dir_reg;
    logic [ANGLE_W-1:0] index_ofs_reg;

    // Sequencer state.
    logic [PHASE_W-1:0] phase_reg,    phase_next;
    logic [VQ_W-1:0]    remain_reg,   remain_next;
    logic [DIV_W-1:0]   div_reg,      div_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [ANGLE_W-1:0] angle_reg,    angle_next;
    logic [VQ_W-1:0]    vq_reg,       vq_next;
    logic               found_reg,    found_next;
    logic [ANGLE_W-1:0] offset_reg,   offset_next;
    logic               fault_reg,    fault_next;

    // Input beat fields.
    logic               in_fire;
    logic               action;
    logic [ANGLE_W-1:0] ref_pos;
    logic [ANGLE_W-1:0] align_pos;
    logic               index_crossed;

    // Ramp step working values.
    logic               ramp_run;
    logic               ramp_down;
    logic [VQ_W-1:0]    ramp_rem_in;
    logic [DIV_W-1:0]   ramp_div_in;
    logic [VQ_W-1:0]    ramp_vq_in;
    logic               ramp_end;

    logic [COUNT_W-1:0] end_count;
    logic               sweep_stop;
    logic [ANGLE_W-1:0] a_el;
    logic [ANGLE_W-1:0] r_el;
    logic [ANGLE_W-1:0] ofs_base;
    logic               busy_res;
    logic               done_res;
    logic [OUT_W-1:0]   result;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign action        = s_axis_tuser;
    assign ref_pos       = s_axis_tdata[ANGLE_W-1:0];
    assign align_pos     = s_axis_tdata[2*ANGLE_W-1:ANGLE_W];
    assign index_crossed = s_axis_tdata[2*ANGLE_W];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg  <= 1'b0;
            vq_limit_reg  <= VQ_W'(1000);
            ramp_div_reg  <= '0;
            sweep_dir_reg <= ANGLE_W'(1);
            index_ofs_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STRATEGY:  strategy_reg  <= cfg_data[0];
                REG_VQ_LIMIT:  vq_limit_reg  <= cfg_data[VQ_W-1:0];
                REG_RAMP_DIV:  ramp_div_reg  <= cfg_data[DIV_W-1:0];
                REG_SWEEP_DIR: sweep_dir_reg <= cfg_data[ANGLE_W-1:0];
                REG_INDEX_OFS: index_ofs_reg <= cfg_data[ANGLE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sweep end test and sync offset arithmetic.
    assign end_count  = strategy_reg ? SWEEP_END_INDEX : SWEEP_END_BLIND;
    assign sweep_stop = (strategy_reg && found_reg) || (count_reg == end_count);
    assign a_el       = to_elec(align_pos);
    assign r_el       = to_elec(ref_pos);
    assign ofs_base   = strategy_reg ? index_ofs_reg : SWEEP_BASE - a_el;

    // Ramp inputs: a fresh ramp loads the limit and clears the divider.
    always_comb
    begin
        ramp_run    = 1'b0;
        ramp_down   = 1'b0;
        ramp_rem_in = remain_reg;
        ramp_div_in = div_reg;
        ramp_vq_in  = vq_reg;
        case (phase_reg)
            PH_UP_ENTER:
            begin
                ramp_run    = 1'b1;
                ramp_rem_in = vq_limit_reg;
                ramp_div_in = '0;
                ramp_vq_in  = '0;
            end
            PH_UP:
            begin
                ramp_run = 1'b1;
            end
            PH_SWEEP:
            begin
                ramp_run    = sweep_stop;
                ramp_down   = 1'b1;
                ramp_rem_in = vq_limit_reg;
                ramp_div_in = '0;
                ramp_vq_in  = vq_limit_reg;
            end
            PH_DOWN:
            begin
                ramp_run  = 1'b1;
                ramp_down = 1'b1;
            end
            default:
            begin
                ramp_run = 1'b0;
            end
        endcase
        ramp_end = (ramp_rem_in == '0);
    end

    // Next state for one beat.
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        div_next    = div_reg;
        count_next  = count_reg;
        angle_next  = angle_reg;
        vq_next     = vq_reg;
        found_next  = found_reg;
        offset_next = offset_reg;
        fault_next  = fault_reg;

        if (action)
        begin
            phase_next = PH_UP_ENTER;
            angle_next = ANGLE_W'(1);
            vq_next    = '0;
            count_next = COUNT_W'(1);
            found_next = 1'b0;
            fault_next = 1'b0;
        end
        else if (ramp_run)
        begin
            // One ramp tick, up or down.
            remain_next = ramp_rem_in;
            div_next    = ramp_div_in;
            vq_next     = ramp_vq_in;
            if (ramp_end)
            begin
                phase_next = ramp_down ? PH_DOWN_ENTER : PH_SWEEP;
            end
            else
            begin
                phase_next = ramp_down ? PH_DOWN : PH_UP;
                if (ramp_div_in == ramp_div_reg)
                begin
                    remain_next = ramp_rem_in - VQ_W'(1);
                    vq_next     = ramp_down ? ramp_rem_in - VQ_W'(1)
                                            : ramp_vq_in + VQ_W'(1);
                    div_next    = '0;
                end
                else
                begin
                    div_next = ramp_div_in + DIV_W'(1);
                end
            end
        end
        else if (phase_reg == PH_SWEEP)
        begin
            // Sweep step; the index pulse counts only in index mode.
            angle_next = angle_reg + sweep_dir_reg;
            count_next = count_reg + COUNT_W'(1);
            if (strategy_reg && index_crossed)
                found_next = 1'b1;
        end
        else if (phase_reg == PH_DOWN_ENTER)
        begin
            offset_next = ofs_base + a_el - r_el;
            fault_next  = strategy_reg && !found_reg;
            phase_next  = PH_DONE;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            remain_reg <= '0;
            div_reg    <= '0;
            count_reg  <= COUNT_W'(1);
            angle_reg  <= '0;
            vq_reg     <= '0;
            found_reg  <= 1'b0;
            offset_reg <= '0;
            fault_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            div_reg    <= div_next;
            count_reg  <= count_next;
            angle_reg  <= angle_next;
            vq_reg     <= vq_next;
            found_reg  <= found_next;
            offset_reg <= offset_next;
            fault_reg  <= fault_next;
        end
    end

    // Result beat.
    assign busy_res = (phase_next != PH_IDLE) && (phase_next != PH_DONE);
    assign done_res = (phase_next == PH_DONE);
    assign result   = OUT_W'({fault_next, done_res, busy_res,
                              offset_next, vq_next, angle_next});

    ras_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTH
    // A start beat always enters the ramp-up entry phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action) |=> (phase_reg == PH_UP_ENTER))
        else $error("start did not enter ramp-up");

    // The sweep count never runs past the longest sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SWEEP_END_INDEX)
        else $error("sweep count overran");

    // Fault is only ever raised together with done.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(fault_reg)) |-> (phase_reg == PH_DONE))
        else $error("fault raised outside finish");
`endif

endmodule

`default_nettype wire
